@@ rtl/bitmap_block_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Block allocator assertion macros
// Shorthand for clocked concurrent assertions, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// Block allocator package
// Sizes, codes, item types and the reset pattern of the free bitmap.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int NUM_BLOCKS  = 1024;
   localparam int FIRST_BLOCK = 4;
   localparam int MAX_RUN     = 64;

   localparam int OP_W     = 1;
   localparam int COUNT_W  = 7;
   localparam int BLOCK_W  = 10;
   localparam int STATUS_W = 2;
   localparam int LEFT_W   = 11;

   // Bitmap is kept as words of WORD_W bits
   localparam int WORD_W      = 32;
   localparam int NUM_WORDS   = NUM_BLOCKS / WORD_W;
   localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
   localparam int BIT_IDX_W   = $clog2(WORD_W);
   localparam int FIRST_W_IDX = FIRST_BLOCK / WORD_W;
   localparam int FREE_RESET  = (FIRST_BLOCK < NUM_BLOCKS) ? NUM_BLOCKS - FIRST_BLOCK : 0;

   localparam logic [WORD_IDX_W-1:0] FIRST_WORD = WORD_IDX_W'(FIRST_W_IDX);

   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_FREE = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COUNT_W-1:0] count;
      logic [BLOCK_W-1:0] block;
   } req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]  granted_block;
      logic                last;
      logic [STATUS_W-1:0] status;
      logic [LEFT_W-1:0]   free_left;
   } rsp_type;

   typedef struct packed {
      logic                  rd_en;
      logic [WORD_IDX_W-1:0] rd_addr;
      logic                  wr_en;
      logic [WORD_IDX_W-1:0] wr_addr;
      logic [WORD_W-1:0]     wr_data;
   } map_cmd_type;

   // Bitmap word as it stands after reset: reserved blocks taken, rest free
   function automatic logic [WORD_W-1:0] reset_word(input logic [WORD_IDX_W-1:0] w);
      int                blk;
      logic [WORD_W-1:0] r;
      r = '0;
      for (int i = 0; i < WORD_W; i++) begin
         blk  = int'(w) * WORD_W + i;
         r[i] = (blk >= FIRST_BLOCK) && (blk < NUM_BLOCKS);
      end
      return r;
   endfunction

endpackage

@@ rtl/bba_map.sv @@
// ----------------------------------------------------------------------------
// Free bitmap store
// Word-wide bitmap memory, one read and one write port, registered read.
// Rows never written read back as their reset pattern.
// ----------------------------------------------------------------------------
module bba_map (
   input  logic                        clock,
   input  logic                        reset,
   input  bba_pkg::map_cmd_type        map_cmd,
   output logic [bba_pkg::WORD_W-1:0]  rd_word
);
   import bba_pkg::*;

   logic [WORD_W-1:0]     mem [NUM_WORDS];
   logic [NUM_WORDS-1:0]  row_valid_ff;
   logic [WORD_W-1:0]     rd_data_ff;
   logic                  rd_valid_ff;
   logic [WORD_IDX_W-1:0] rd_addr_ff;

   // Memory array: no reset
   always_ff @(posedge clock) begin
      if (map_cmd.wr_en) begin
         mem[map_cmd.wr_addr] <= map_cmd.wr_data;
      end
      if (map_cmd.rd_en) begin
         rd_data_ff <= mem[map_cmd.rd_addr];
         rd_addr_ff <= map_cmd.rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (map_cmd.wr_en) begin
            row_valid_ff[map_cmd.wr_addr] <= 1'b1;
         end
         if (map_cmd.rd_en) begin
            rd_valid_ff <= row_valid_ff[map_cmd.rd_addr];
         end
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff : reset_word(rd_addr_ff);

endmodule

@@ rtl/bitmap_block_allocator.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit free-block allocator over a word-wide bitmap memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per request. op ALLOC asks for count blocks (1..64),
//            op FREE returns one block. req_ready is high only while the
//            block is idle; one request is worked on at a time.
//   rsp_*  : one item per granted block (last marks the final one), or a
//            single item for a rejected allocate, a free, or a bad free.
//            free_left is the free count after the whole request.
// Sequence:
//   Rejected allocate or out-of-range free: result sent from S_ONE.
//   Free: read, latch the word, check and write back, then send the result.
//   Allocate: for each bitmap word visited, latch its read data, claim one
//   block per cycle while the output slot is free, and once the word is
//   exhausted write it back and fetch the next; the final claim writes back
//   its word. The next request can be taken while the last result item
//   still waits in the output register.
// Reset: map rows are marked unwritten and read as reserved blocks taken,
//   rest free; no clearing pass. The free count loads its full value.
// Stall: a held result freezes the scan until rsp_ready; nothing is lost.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bba_pkg::rsp_type rsp_data
);
   import bba_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GET  = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_FCHK = 3'd3;
   localparam logic [2:0] S_ONE  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [WORD_IDX_W-1:0] word_addr_ff, word_addr_in;
   logic [BIT_IDX_W-1:0]  bit_ff, bit_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [COUNT_W-1:0]    rem_ff, rem_in;
   logic [LEFT_W-1:0]     free_total_ff, free_total_in;
   rsp_type               res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   map_cmd_type           map_cmd;
   logic [WORD_W-1:0]     map_rd_word;

   logic                  out_free;
   logic                  alloc_reject;
   logic                  free_bad_range;
   logic [BIT_IDX_W-1:0]  low_idx;
   logic [WORD_W-1:0]     bit_mask;
   logic [WORD_W-1:0]     claim_mask;

   bba_map u_map (
      .clock   (clock),
      .reset   (reset),
      .map_cmd (map_cmd),
      .rd_word (map_rd_word)
   );

   // Output slot can take a new item when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign alloc_reject = (req_data.count == '0)
                      || (req_data.count > COUNT_W'(MAX_RUN))
                      || (LEFT_W'(req_data.count) > free_total_ff);

   assign free_bad_range = (32'(req_data.block) < FIRST_BLOCK)
                        || (32'(req_data.block) >= NUM_BLOCKS);

   // Lowest free block in the latched word
   always_comb begin
      low_idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (word_ff[i]) begin
            low_idx = BIT_IDX_W'(i);
         end
      end
   end

   assign claim_mask = WORD_W'(1) << low_idx;
   assign bit_mask   = WORD_W'(1) << bit_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      word_addr_in  = word_addr_ff;
      bit_in        = bit_ff;
      word_in       = word_ff;
      rem_in        = rem_ff;
      free_total_in = free_total_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      map_cmd       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_data.op;
               if (req_data.op == OP_ALLOC) begin
                  if (alloc_reject) begin
                     res_in.granted_block = '0;
                     res_in.last          = 1'b1;
                     res_in.status        = STAT_NO_SPACE;
                     res_in.free_left     = free_total_ff;
                     state_in             = S_ONE;
                  end else begin
                     // Fit is guaranteed: commit the new count up front
                     free_total_in   = free_total_ff - LEFT_W'(req_data.count);
                     rem_in          = req_data.count;
                     word_addr_in    = FIRST_WORD;
                     map_cmd.rd_en   = 1'b1;
                     map_cmd.rd_addr = FIRST_WORD;
                     state_in        = S_GET;
                  end
               end else begin
                  if (free_bad_range) begin
                     res_in.granted_block = req_data.block;
                     res_in.last          = 1'b1;
                     res_in.status        = STAT_BAD_FREE;
                     res_in.free_left     = free_total_ff;
                     state_in             = S_ONE;
                  end else begin
                     word_addr_in    = req_data.block[BLOCK_W-1 -: WORD_IDX_W];
                     bit_in          = req_data.block[BIT_IDX_W-1:0];
                     map_cmd.rd_en   = 1'b1;
                     map_cmd.rd_addr = req_data.block[BLOCK_W-1 -: WORD_IDX_W];
                     state_in        = S_GET;
                  end
               end
            end
         end

         S_GET: begin
            word_in  = map_rd_word;
            state_in = (op_ff == OP_ALLOC) ? S_SCAN : S_FCHK;
         end

         S_FCHK: begin
            res_in.granted_block = {word_addr_ff, bit_ff};
            res_in.last          = 1'b1;
            if ((word_ff & bit_mask) != '0) begin
               // Already free: flag, change nothing
               res_in.status    = STAT_BAD_FREE;
               res_in.free_left = free_total_ff;
            end else begin
               free_total_in    = free_total_ff + LEFT_W'(1);
               res_in.status    = STAT_OK;
               res_in.free_left = free_total_ff + LEFT_W'(1);
               map_cmd.wr_en    = 1'b1;
               map_cmd.wr_addr  = word_addr_ff;
               map_cmd.wr_data  = word_ff | bit_mask;
            end
            state_in = S_ONE;
         end

         S_ONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         S_SCAN: begin
            if (word_ff != '0) begin
               // Claim one block per cycle while the output slot is free
               if (out_free) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.granted_block = {word_addr_ff, low_idx};
                  rsp_data_in.last          = (rem_ff == COUNT_W'(1));
                  rsp_data_in.status        = STAT_OK;
                  rsp_data_in.free_left     = free_total_ff;
                  word_in                   = word_ff & ~claim_mask;
                  rem_in                    = rem_ff - COUNT_W'(1);
                  if (rem_ff == COUNT_W'(1)) begin
                     map_cmd.wr_en   = 1'b1;
                     map_cmd.wr_addr = word_addr_ff;
                     map_cmd.wr_data = word_ff & ~claim_mask;
                     state_in        = S_IDLE;
                  end
               end
            end else begin
               // Word exhausted: write it back and fetch the next one
               map_cmd.wr_en   = 1'b1;
               map_cmd.wr_addr = word_addr_ff;
               map_cmd.wr_data = word_ff;
               map_cmd.rd_en   = 1'b1;
               map_cmd.rd_addr = word_addr_ff + WORD_IDX_W'(1);
               word_addr_in    = word_addr_ff + WORD_IDX_W'(1);
               state_in        = S_GET;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         free_total_ff <= LEFT_W'(FREE_RESET);
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_total_ff <= free_total_in;
      end
   end

   // Payload and working registers: no reset
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      word_addr_ff <= word_addr_in;
      bit_ff       <= bit_in;
      word_ff      <= word_in;
      rem_ff       <= rem_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/bba_checker.sv @@
// ----------------------------------------------------------------------------
// Block allocator port checker
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_macros.svh"

module bba_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bba_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bba_pkg::rsp_type rsp_data
);
   import bba_pkg::*;

   // Held result keeps its payload
   `BBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // One request at a time: taking an item drops ready
   `BBA_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")

   // Any failure is a single, final item
   `BBA_ASSERT_NOW(a_fail_last, rsp_valid && (rsp_data.status != STAT_OK), rsp_data.last, "failure result not marked last")

   // Free count never exceeds the usable blocks
   `BBA_ASSERT_NOW(a_left_bound, rsp_valid, 32'(rsp_data.free_left) <= FREE_RESET, "free count out of range")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
